// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property with asynchronous active-low reset disable.
`define CFT_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CFT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/cft_pkg.sv =====
// ---------------------------------------------------------------------------
// cft_pkg
// Constants and types for the CSV field tokenizer.
// ---------------------------------------------------------------------------
package cft_pkg;

	localparam logic [7:0] QUOTE_BYTE    = 8'd34;
	localparam logic [7:0] CR_BYTE       = 8'd13;
	localparam logic [7:0] FIELD_SEP_RST = 8'd44;
	localparam logic [7:0] ROW_SEP_RST   = 8'd10;

	// results per field are capped at this count
	localparam int MAX_RESULTS = 32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIELD_SEP  = 2'd0,
		CFG_ROW_SEP    = 2'd1,
		CFG_CRLF_ROWS  = 2'd2,
		CFG_SKIP_FIRST = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		QP_NONE   = 3'b001,
		QP_OPEN   = 3'b010,
		QP_CLOSED = 3'b100
	} qphase_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_REPLAY = 7'b0000010,
		ST_START  = 7'b0000100,
		ST_READ   = 7'b0001000,
		ST_EVAL   = 7'b0010000,
		ST_EMPTY  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       empty;
		logic       fend;
		logic       rend;
		logic       first;
		logic       match;
		logic       trunc;
	} result_t;

endpackage

// ===== design/csv_field_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// csv_field_tokenizer_unit
// Splits CSV text into fields and emits unescaped field bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one text byte per transaction,
//   with last_byte marking the end of the input. Output channel
//   (out_valid/out_stall) carries one result per unescaped content byte, or
//   one empty_field result for a field with no content.
//   A content byte goes straight into the field store while idle. A held
//   CR that turns into content is written first and the byte after it is
//   replayed from a hold register. A byte that ends a field starts the emit
//   walk: field setup, one read and one evaluate per buffered byte walked
//   through the field store (or the empty-field state for an empty field),
//   then bookkeeping; in_stall is high meanwhile. The field store is a
//   single-port synchronous RAM, FIELD_DEPTH bytes, whose registered read
//   output sets the read-then-evaluate step of the emit walk.
//   Reset: registers go to defaults, the field store needs no clearing.
//   When the receiver stalls, the output register holds its result and the
//   walk waits; an input byte is still taken while idle.
//   The user must write configuration only while the block is idle;
//   the block itself does not enforce it.
// ---------------------------------------------------------------------------
module csv_field_tokenizer_unit #(
	parameter int FIELD_DEPTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [cft_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cft_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_byte,
	output logic                           empty_field,
	output logic                           field_end,
	output logic                           row_end,
	output logic                           first_row,
	output logic                           count_matches,
	output logic                           truncated
);

	localparam int AW = $clog2(FIELD_DEPTH);
	localparam int LW = $clog2(FIELD_DEPTH + 1);
	localparam logic [LW-1:0] DEPTH_L = LW'(FIELD_DEPTH);

	cft_pkg::state_t  state_q;
	cft_pkg::qphase_t qp_q, qp_n;

	logic [7:0]    field_sep_q, row_sep_q;
	logic          crlf_q, skip_q;
	logic [LW-1:0] len_q;
	logic          ovf_q, crp_q, crp_n;
	logic [7:0]    fields_q, header_q;
	logic          first_q;
	logic [LW-1:0] cnt_a_q, cnt_b_q, cnt_bp_q;
	logic          pa_q, pb_q, fq_q, lq_q;
	logic          fin_row_q;
	logic [7:0]    hold_byte_q;
	logic          hold_last_q;
	logic [AW-1:0] rd_ptr_q;
	logic [LW-1:0] emit_cnt_q;
	logic          pe_q;
	logic [7:0]    mem [FIELD_DEPTH];
	logic [7:0]    mem_rd_q;
	logic          out_valid_q;
	cft_pkg::result_t out_q;

	logic [7:0]    src_byte;
	logic          src_last, proc_go, outside;
	logic          put_en, fin, fin_row, replay, wr_en;
	logic [7:0]    put_data;
	logic          x_quote, a_fold, b_fold;
	logic          strip, cap, show, match, last_r, rd_quote, fold, out_free;
	logic          trunc_c, load_byte, load_empty;
	logic [LW-1:0] m_raw, m_fin;
	logic [7:0]    n_cnt;

	// ---- byte classification ----
	always_comb begin
		src_byte = (state_q == cft_pkg::ST_IDLE) ? data_byte : hold_byte_q;
		src_last = (state_q == cft_pkg::ST_IDLE) ? last_byte : hold_last_q;
		proc_go  = ((state_q == cft_pkg::ST_IDLE) && in_valid) ||
			(state_q == cft_pkg::ST_REPLAY);
		outside  = (qp_q != cft_pkg::QP_OPEN);
		put_en   = 1'b0;
		put_data = src_byte;
		crp_n    = crp_q;
		qp_n     = qp_q;
		fin      = 1'b0;
		fin_row  = 1'b0;
		replay   = 1'b0;
		if (proc_go) begin
			if (crp_q && (src_byte == row_sep_q)) begin
				fin     = 1'b1;
				fin_row = 1'b1;
			end else if (crp_q) begin
				// held CR becomes content, byte is handled next cycle
				put_en   = 1'b1;
				put_data = cft_pkg::CR_BYTE;
				crp_n    = 1'b0;
				replay   = 1'b1;
			end else if (outside && (src_byte == field_sep_q)) begin
				fin     = 1'b1;
				fin_row = src_last;
			end else if (outside && (src_byte == row_sep_q)) begin
				fin     = 1'b1;
				fin_row = 1'b1;
			end else if (outside && crlf_q && (src_byte == cft_pkg::CR_BYTE)) begin
				crp_n = 1'b1;
				if (src_last) begin
					put_en   = 1'b1;
					put_data = cft_pkg::CR_BYTE;
					fin      = 1'b1;
					fin_row  = 1'b1;
				end
			end else begin
				put_en = 1'b1;
				if (src_byte == cft_pkg::QUOTE_BYTE) begin
					qp_n = (qp_q == cft_pkg::QP_OPEN) ? cft_pkg::QP_CLOSED : cft_pkg::QP_OPEN;
				end
				if (src_last) begin
					fin     = 1'b1;
					fin_row = 1'b1;
				end
			end
		end
	end

	// running fold counts: scan A from entry 0, scan B from entry 1
	assign wr_en   = put_en && (len_q < DEPTH_L);
	assign x_quote = (put_data == cft_pkg::QUOTE_BYTE);
	assign a_fold  = pa_q && x_quote;
	assign b_fold  = pb_q && x_quote;

	// ---- emit walk ----
	assign strip    = (len_q >= LW'(2)) && fq_q && lq_q;
	assign m_raw    = strip ? cnt_bp_q : cnt_a_q;
	assign cap      = 32'(m_raw) > cft_pkg::MAX_RESULTS;
	assign m_fin    = cap ? LW'(cft_pkg::MAX_RESULTS) : m_raw;
	assign trunc_c  = ovf_q || cap;
	assign show     = !(skip_q && first_q);
	assign n_cnt    = (fields_q == 8'hFF) ? fields_q : fields_q + 8'd1;
	assign match    = fin_row_q && (first_q || (n_cnt == header_q));
	assign last_r   = (emit_cnt_q == m_fin - LW'(1));
	assign rd_quote = (mem_rd_q == cft_pkg::QUOTE_BYTE);
	assign fold     = pe_q && rd_quote;
	assign out_free = !out_valid_q || !out_stall;

	assign load_byte  = (state_q == cft_pkg::ST_EVAL) && !fold && out_free;
	assign load_empty = (state_q == cft_pkg::ST_EMPTY) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cft_pkg::ST_IDLE;
			field_sep_q <= cft_pkg::FIELD_SEP_RST;
			row_sep_q   <= cft_pkg::ROW_SEP_RST;
			crlf_q      <= 1'b0;
			skip_q      <= 1'b0;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			qp_q        <= cft_pkg::QP_NONE;
			crp_q       <= 1'b0;
			fields_q    <= '0;
			header_q    <= '0;
			first_q     <= 1'b1;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			cnt_bp_q    <= '0;
			pa_q        <= 1'b0;
			pb_q        <= 1'b0;
			fq_q        <= 1'b0;
			lq_q        <= 1'b0;
			fin_row_q   <= 1'b0;
			rd_ptr_q    <= '0;
			emit_cnt_q  <= '0;
			pe_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cft_pkg::cfg_idx_t'(cfg_index))
					cft_pkg::CFG_FIELD_SEP:  field_sep_q <= cfg_data;
					cft_pkg::CFG_ROW_SEP:    row_sep_q   <= cfg_data;
					cft_pkg::CFG_CRLF_ROWS:  crlf_q      <= cfg_data[0];
					cft_pkg::CFG_SKIP_FIRST: skip_q      <= cfg_data[0];
					default: ;
				endcase
			end

			if (wr_en) begin
				cnt_a_q <= a_fold ? cnt_a_q : cnt_a_q + LW'(1);
				pa_q    <= !a_fold && x_quote;
				if (len_q != '0) begin
					cnt_bp_q <= cnt_b_q;
					cnt_b_q  <= b_fold ? cnt_b_q : cnt_b_q + LW'(1);
					pb_q     <= !b_fold && x_quote;
				end else begin
					fq_q <= x_quote;
				end
				lq_q  <= x_quote;
				len_q <= len_q + LW'(1);
			end else if (put_en) begin
				ovf_q <= 1'b1;
			end
			qp_q  <= qp_n;
			crp_q <= crp_n;
			if (fin) begin
				fin_row_q <= fin_row;
			end

			if (load_byte || load_empty) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				cft_pkg::ST_IDLE, cft_pkg::ST_REPLAY: begin
					if (proc_go) begin
						state_q <= fin ? cft_pkg::ST_START :
							(replay ? cft_pkg::ST_REPLAY : cft_pkg::ST_IDLE);
					end
				end
				cft_pkg::ST_START: begin
					rd_ptr_q   <= strip ? AW'(1) : '0;
					emit_cnt_q <= '0;
					pe_q       <= 1'b0;
					if (!show) begin
						state_q <= cft_pkg::ST_DONE;
					end else if (m_fin == '0) begin
						state_q <= cft_pkg::ST_EMPTY;
					end else begin
						state_q <= cft_pkg::ST_READ;
					end
				end
				cft_pkg::ST_READ: begin
					rd_ptr_q <= rd_ptr_q + AW'(1);
					state_q  <= cft_pkg::ST_EVAL;
				end
				cft_pkg::ST_EVAL: begin
					if (fold) begin
						// second quote of a doubled pair
						pe_q    <= 1'b0;
						state_q <= cft_pkg::ST_READ;
					end else if (out_free) begin
						pe_q       <= rd_quote;
						emit_cnt_q <= emit_cnt_q + LW'(1);
						state_q    <= last_r ? cft_pkg::ST_DONE : cft_pkg::ST_READ;
					end
				end
				cft_pkg::ST_EMPTY: begin
					if (out_free) begin
						state_q <= cft_pkg::ST_DONE;
					end
				end
				cft_pkg::ST_DONE: begin
					if (fin_row_q) begin
						if (first_q) begin
							header_q <= n_cnt;
							first_q  <= 1'b0;
						end
						fields_q <= '0;
					end else begin
						fields_q <= n_cnt;
					end
					len_q    <= '0;
					ovf_q    <= 1'b0;
					qp_q     <= cft_pkg::QP_NONE;
					crp_q    <= 1'b0;
					cnt_a_q  <= '0;
					cnt_b_q  <= '0;
					cnt_bp_q <= '0;
					pa_q     <= 1'b0;
					pb_q     <= 1'b0;
					fq_q     <= 1'b0;
					lq_q     <= 1'b0;
					state_q  <= cft_pkg::ST_IDLE;
				end
				default: state_q <= cft_pkg::ST_IDLE;
			endcase
		end
	end

	// field store: writes only while buffering, reads only while walking
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[len_q[AW-1:0]] <= put_data;
		end
		if (state_q == cft_pkg::ST_READ) begin
			mem_rd_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == cft_pkg::ST_IDLE) && replay) begin
			hold_byte_q <= src_byte;
			hold_last_q <= src_last;
		end
		if (load_byte) begin
			out_q.data  <= mem_rd_q;
			out_q.empty <= 1'b0;
			out_q.fend  <= last_r;
			out_q.rend  <= last_r && fin_row_q;
			out_q.first <= first_q;
			out_q.match <= last_r && match;
			out_q.trunc <= trunc_c;
		end else if (load_empty) begin
			out_q.data  <= 8'd0;
			out_q.empty <= 1'b1;
			out_q.fend  <= 1'b1;
			out_q.rend  <= fin_row_q;
			out_q.first <= first_q;
			out_q.match <= match;
			out_q.trunc <= trunc_c;
		end
	end

	assign in_stall      = (state_q != cft_pkg::ST_IDLE);
	assign out_valid     = out_valid_q;
	assign out_byte      = out_q.data;
	assign empty_field   = out_q.empty;
	assign field_end     = out_q.fend;
	assign row_end       = out_q.rend;
	assign first_row     = out_q.first;
	assign count_matches = out_q.match;
	assign truncated     = out_q.trunc;

endmodule

// ===== design/cft_checker.sv =====
// ---------------------------------------------------------------------------
// cft_checker
// Port-level checks for the CSV field tokenizer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cft_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       empty_field,
	input logic       field_end,
	input logic       row_end,
	input logic       count_matches
);

	// stalled transaction holds
	`CFT_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(field_end), "output changed while stalled")

	`CFT_ASSERT_IMP(a_empty_shape, clk, arst_n, out_valid && empty_field, field_end && (out_byte == 8'd0), "empty field result malformed")

	`CFT_ASSERT_IMP(a_row_in_field, clk, arst_n, out_valid && row_end, field_end, "row end without field end")

	`CFT_ASSERT_IMP(a_match_at_row, clk, arst_n, out_valid && count_matches, row_end, "count match off a row end")

	// a new result only comes out of the emit walk, where input is held off
	`CFT_ASSERT_IMP(a_emit_busy, clk, arst_n, $rose(out_valid), $past(in_stall), "result while idle")

endmodule

bind csv_field_tokenizer_unit cft_checker u_cft_checker (.*);

// ===== bench/csv_field_tokenizer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_checker
// Watches the byte, result and register ports of the CSV field tokenizer.
// Keeps its own copy of the tokenizer state, predicts the field results for
// every accepted byte and compares each accepted result against the oldest
// prediction. Hands a failure count and the number of results still due to
// the testbench top.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_checker #(
	parameter int FIELD_DEPTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  cft_pkg::cfg_idx_t              cfg_index,
	input  logic [cft_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [7:0]                     out_byte,
	input  logic                           empty_field,
	input  logic                           field_end,
	input  logic                           row_end,
	input  logic                           first_row,
	input  logic                           count_matches,
	input  logic                           truncated,
	output int                             fail_count,
	output int                             tokens_due,
	output int                             tokens_seen
);

	localparam int MAX_REPORTS = 50;

	logic [7:0] fsep, rsep;
	logic       crlf, skip_first;

	logic [7:0]       fstore [FIELD_DEPTH];
	int               flen;
	cft_pkg::qphase_t qphase;
	logic             cr_held;
	logic [7:0]       row_fields, head_fields;
	logic             in_first, over;

	cft_pkg::result_t pending_tokens [$];

	function automatic void queue_result(input cft_pkg::result_t r);
		pending_tokens = {pending_tokens, r};
	endfunction

	function automatic void store_byte(input logic [7:0] b);
		if (flen < FIELD_DEPTH) begin
			fstore[flen] = b;
			flen++;
		end else
			over = 1'b1;
	endfunction

	// strip outer quotes, fold doubled quotes, queue one result per content byte
	function automatic void close_field(input logic row_done);
		logic [7:0]       body [FIELD_DEPTH];
		int               len, lo, hi, i, cnt, m;
		logic             first_f, show, cnt_ok, trunc;
		logic [7:0]       n;
		cft_pkg::result_t r;
		len = (flen < FIELD_DEPTH) ? flen : FIELD_DEPTH;
		lo = 0;
		hi = len;
		m = 0;
		first_f = in_first;
		show = !(skip_first && in_first);
		cnt_ok = 1'b0;
		trunc = over;
		n = (row_fields < 8'd255) ? row_fields + 8'd1 : 8'd255;
		if (len >= 2 && fstore[0] == cft_pkg::QUOTE_BYTE &&
		    fstore[len-1] == cft_pkg::QUOTE_BYTE) begin
			lo = 1;
			hi = len - 1;
		end
		for (i = lo; i < hi; i++) begin
			body[m] = fstore[i];
			m++;
			if (fstore[i] == cft_pkg::QUOTE_BYTE && i + 1 < hi &&
			    fstore[i+1] == cft_pkg::QUOTE_BYTE)
				i++;
		end
		if (row_done) begin
			if (in_first) begin
				head_fields = n;
				in_first = 1'b0;
			end
			cnt_ok = (n == head_fields);
			row_fields = 8'd0;
		end else
			row_fields = n;
		if (show) begin
			if (m == 0) begin
				r.data = 8'd0;
				r.empty = 1'b1;
				r.fend = 1'b1;
				r.rend = row_done;
				r.first = first_f;
				r.match = cnt_ok;
				r.trunc = trunc;
				queue_result(r);
			end else begin
				cnt = m;
				if (cnt > cft_pkg::MAX_RESULTS) begin
					cnt = cft_pkg::MAX_RESULTS;
					trunc = 1'b1;
				end
				for (i = 0; i < cnt; i++) begin
					r.data = body[i];
					r.empty = 1'b0;
					r.fend = (i == cnt - 1);
					r.rend = r.fend && row_done;
					r.first = first_f;
					r.match = r.fend ? cnt_ok : 1'b0;
					r.trunc = trunc;
					queue_result(r);
				end
			end
		end
		flen = 0;
		over = 1'b0;
		qphase = cft_pkg::QP_NONE;
		cr_held = 1'b0;
	endfunction

	function automatic void tokenize_byte(input logic [7:0] b, input logic last);
		logic closed, outside;
		closed = 1'b0;
		if (cr_held) begin
			if (b == rsep) begin
				close_field(1'b1);
				closed = 1'b1;
			end else begin
				store_byte(cft_pkg::CR_BYTE);
				cr_held = 1'b0;
			end
		end
		if (!closed) begin
			outside = (qphase != cft_pkg::QP_OPEN);
			if (outside && b == fsep) begin
				close_field(last);
				closed = last;
			end else if (outside && b == rsep) begin
				close_field(1'b1);
				closed = 1'b1;
			end else if (outside && crlf && b == cft_pkg::CR_BYTE)
				cr_held = 1'b1;
			else begin
				store_byte(b);
				if (b == cft_pkg::QUOTE_BYTE)
					qphase = (qphase == cft_pkg::QP_OPEN) ? cft_pkg::QP_CLOSED :
						cft_pkg::QP_OPEN;
			end
		end
		// end of input closes whatever is still open
		if (last && !closed &&
		    (row_fields != 0 || flen != 0 || over || cr_held ||
		     qphase != cft_pkg::QP_NONE)) begin
			if (cr_held)
				store_byte(cft_pkg::CR_BYTE);
			close_field(1'b1);
		end
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cft_pkg::result_t want;
		if (!arst_n) begin
			fsep = cft_pkg::FIELD_SEP_RST;
			rsep = cft_pkg::ROW_SEP_RST;
			crlf = 1'b0;
			skip_first = 1'b0;
			flen = 0;
			qphase = cft_pkg::QP_NONE;
			cr_held = 1'b0;
			row_fields = 8'd0;
			head_fields = 8'd0;
			in_first = 1'b1;
			over = 1'b0;
			pending_tokens.delete();
			tokens_due <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					cft_pkg::CFG_FIELD_SEP:  fsep = cfg_data;
					cft_pkg::CFG_ROW_SEP:    rsep = cfg_data;
					cft_pkg::CFG_CRLF_ROWS:  crlf = cfg_data[0];
					cft_pkg::CFG_SKIP_FIRST: skip_first = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				tokens_seen++;
				if (pending_tokens.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: result %0h arrived with nothing expected",
						         $time, out_byte);
				end else begin
					want = pending_tokens.pop_front();
					check_field("out_byte", want.data, out_byte);
					check_field("empty_field", want.empty, empty_field);
					check_field("field_end", want.fend, field_end);
					check_field("row_end", want.rend, row_end);
					check_field("first_row", want.first, first_row);
					check_field("count_matches", want.match, count_matches);
					check_field("truncated", want.trunc, truncated);
				end
			end
			if (in_valid && !in_stall)
				tokenize_byte(data_byte, last_byte);
			tokens_due <= pending_tokens.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the CSV field tokenizer testbench. Drives a short directed text,
// then random CSV rows (plain, quoted, empty, overflowing and noisy fields)
// under several register settings and back-pressure patterns, including one
// long receiver hold. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;

	localparam int FIELD_DEPTH  = 32;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_BYTES  = 55;
	localparam int NUM_PHASES   = 6;

	typedef struct {
		logic [7:0] fs;
		logic [7:0] rs;
		logic       crlf;
		logic       skip;
	} setting_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_wr_en = 1'b0;
	cft_pkg::cfg_idx_t              cfg_index = cft_pkg::CFG_FIELD_SEP;
	logic [cft_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [7:0]                     data_byte = '0;
	logic                           last_byte = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [7:0]                     out_byte;
	logic                           empty_field, field_end, row_end;
	logic                           first_row, count_matches, truncated;
	int                             fail_count, tokens_due, tokens_seen;

	int         snd_idle = 0;
	int         rcv_idle = 0;
	logic       squeeze = 1'b0;
	int         bytes_sent = 0;
	int         settings_used = 0;
	int         cycles = 0;
	logic [7:0] cur_fs = cft_pkg::FIELD_SEP_RST;
	logic [7:0] cur_rs = cft_pkg::ROW_SEP_RST;
	logic       cur_crlf = 1'b0;

	setting_t plan [NUM_PHASES] = '{
		'{cft_pkg::FIELD_SEP_RST, cft_pkg::ROW_SEP_RST, 1'b0, 1'b0},
		'{cft_pkg::FIELD_SEP_RST, cft_pkg::ROW_SEP_RST, 1'b1, 1'b1},
		'{8'd0,                   8'd255,               1'b1, 1'b0},
		'{8'd255,                 8'd0,                 1'b0, 1'b1},
		'{8'd9,                   cft_pkg::CR_BYTE,     1'b1, 1'b0},
		'{8'd59,                  cft_pkg::ROW_SEP_RST, 1'b1, 1'b0}
	};

	csv_field_tokenizer_unit #(.FIELD_DEPTH(FIELD_DEPTH)) dut (.*);

	csv_field_tokenizer_checker #(.FIELD_DEPTH(FIELD_DEPTH)) checker_i (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk)
		out_stall <= squeeze || ($urandom_range(99) < rcv_idle);

	// long receiver hold while bytes keep coming
	initial begin
		wait (bytes_sent >= 150);
		@(posedge clk);
		squeeze <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		squeeze <= 1'b0;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_byte(txt[i], 1'b0);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (tokens_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input setting_t s);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= cft_pkg::CFG_FIELD_SEP;
		cfg_data <= s.fs;
		@(posedge clk);
		cfg_index <= cft_pkg::CFG_ROW_SEP;
		cfg_data <= s.rs;
		@(posedge clk);
		cfg_index <= cft_pkg::CFG_CRLF_ROWS;
		cfg_data <= {7'd0, s.crlf};
		@(posedge clk);
		cfg_index <= cft_pkg::CFG_SKIP_FIRST;
		cfg_data <= {7'd0, s.skip};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_fs = s.fs;
		cur_rs = s.rs;
		cur_crlf = s.crlf;
		settings_used++;
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == cur_fs || b == cur_rs || b == cft_pkg::QUOTE_BYTE);
		return b;
	endfunction

	task automatic send_field();
		int kind, len;
		kind = $urandom_range(99);
		if (kind < 40) begin
			len = $urandom_range(6);
			repeat (len) send_byte(plain_byte(), 1'b0);
		end else if (kind < 75) begin
			send_byte(cft_pkg::QUOTE_BYTE, 1'b0);
			len = $urandom_range(6);
			repeat (len) begin
				case ($urandom_range(5))
					0: begin
						send_byte(cft_pkg::QUOTE_BYTE, 1'b0);
						send_byte(cft_pkg::QUOTE_BYTE, 1'b0);
					end
					1: send_byte(cur_fs, 1'b0);
					2: send_byte(cur_rs, 1'b0);
					3: send_byte(cft_pkg::CR_BYTE, 1'b0);
					default: send_byte(plain_byte(), 1'b0);
				endcase
			end
			send_byte(cft_pkg::QUOTE_BYTE, 1'b0);
		end else if (kind < 80) begin
			// around the buffer depth, often past it
			len = $urandom_range(40, 28);
			repeat (len) send_byte(plain_byte(), 1'b0);
		end else if (kind < 90) begin
			len = $urandom_range(4, 1);
			repeat (len) send_byte(8'($urandom_range(255)), 1'b0);
		end
	endtask

	task automatic send_row();
		int nf;
		nf = ($urandom_range(3) == 0) ? $urandom_range(6, 1) : 3;
		for (int f = 0; f < nf; f++) begin
			send_field();
			if (f < nf - 1)
				send_byte(cur_fs, 1'b0);
		end
		if (cur_crlf && $urandom_range(1))
			send_byte(cft_pkg::CR_BYTE, 1'b0);
		send_byte(cur_rs, 1'b0);
	endtask

	initial begin
		int start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// header row of four fields, then a blank line
		set_regs(plan[0]);
		send_text("\"a,\"\"b\"\"\",\"\",,\n\n");
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(cur_fs, 1'b1);
		send_byte(cft_pkg::QUOTE_BYTE, 1'b1);
		settle();

		// held CR: dropped before a row end, kept as content otherwise
		set_regs('{cft_pkg::FIELD_SEP_RST, cft_pkg::ROW_SEP_RST, 1'b1, 1'b0});
		send_text("q\015\012\015s");
		send_byte(cft_pkg::CR_BYTE, 1'b1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			set_regs(plan[p]);
			case (p % 3)
				0: begin
					snd_idle <= 27;
					rcv_idle <= 67;
				end
				1: begin
					snd_idle <= 67;
					rcv_idle <= 27;
				end
				default: begin
					snd_idle <= 0;
					rcv_idle <= 0;
				end
			endcase
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES)
				send_row();
			send_byte(plain_byte(), 1'b1);
		end
		settle();

		$display("Run covered %0d text bytes and %0d field results under %0d register settings,",
		         bytes_sent, tokens_seen, settings_used);
		$display("with quoted, empty, overflowing and CRLF-terminated fields and a long hold.");
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/cft_pkg.sv
design/csv_field_tokenizer_unit.sv
design/cft_checker.sv
bench/csv_field_tokenizer_checker.sv
bench/tb.sv
